### sv/assert_macros.svh
// Assertion macros shared by the key auto-repeat RTL.
// No dependencies; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define AKR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition never holds at a clock edge outside reset.
`define AKR_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define AKR_ASSERT(lbl, clk, rst, prop, msg)
`define AKR_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

### sv/akr_pkg.sv
// Shared types and constants of the key auto-repeat controller.
// No dependencies; used by every module of the block.
package akr_pkg;

   // request function codes
   localparam logic [1:0] FUNC_PRESS   = 2'd0;
   localparam logic [1:0] FUNC_RELEASE = 2'd1;
   localparam logic [1:0] FUNC_SCAN    = 2'd2;
   localparam logic [1:0] FUNC_CLEAR   = 2'd3;

   // event kinds
   localparam logic [1:0] EV_PRESSED  = 2'd0;
   localparam logic [1:0] EV_REPEATED = 2'd1;
   localparam logic [1:0] EV_RELEASED = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_FIRST_DELAY = 2'd0;
   localparam logic [1:0] CSR_PERIOD      = 2'd1;
   localparam logic [1:0] CSR_MAX_REPEATS = 2'd2;

   localparam logic [15:0] FIRST_DELAY_RESET = 16'd600;
   localparam logic [15:0] PERIOD_RESET      = 16'd150;
   localparam logic [31:0] NO_LIMIT          = 32'hFFFF_FFFF;

   localparam int Q_DEPTH = 2;

   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  key;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [5:0] event_key;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_PRESS,
      OP_RELEASE,
      OP_SCAN,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [5:0]  key;
      logic [31:0] now_ms;
   } cmd_type;

   typedef struct packed {
      logic [15:0] first_delay;
      logic [15:0] period;
      logic [31:0] max_repeats;
      logic [47:0] limit;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_PRESSED  = 3'd1,
      ST_FIRST    = 3'd2,
      ST_REPEAT   = 3'd3,
      ST_RELEASED = 3'd4,
      ST_REL_IDLE = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_PRESS,
      B_SCAN,
      B_SCAN_END,
      B_FLUSH
   } back_state_type;

endpackage

### sv/akr_front.sv
// Front end: takes requests, drops press/release of invalid keys, encodes ops.
// Depends on akr_pkg.
module akr_front
   import akr_pkg::*;
#(
   parameter int NUM_KEYS = 64
) (
   input  logic    start,
   input  req_type req_item,
   input  logic    q_full,
   output logic    busy,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic accept;
   logic key_ok;

   assign busy   = q_full;
   assign accept = start && !q_full;
   assign key_ok = (req_item.key != 6'd0) && ({1'b0, req_item.key} < 7'(NUM_KEYS));

   always_comb begin
      q_cmd.key    = req_item.key;
      q_cmd.now_ms = req_item.now_ms;
      q_cmd.op     = OP_SCAN;
      q_push       = 1'b0;
      case (req_item.func)
         FUNC_PRESS: begin
            q_cmd.op = OP_PRESS;
            q_push   = accept && key_ok;
         end
         FUNC_RELEASE: begin
            q_cmd.op = OP_RELEASE;
            q_push   = accept && key_ok;
         end
         FUNC_SCAN: begin
            q_cmd.op = OP_SCAN;
            q_push   = accept;
         end
         default: begin
            q_cmd.op = OP_CLEAR;
            q_push   = accept;
         end
      endcase
   end

endmodule

### sv/akr_queue.sv
// Short command queue between front and back end.
// Depends on akr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module akr_queue
   import akr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    not_empty,
   output logic    full
);

   localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CW = $clog2(Q_DEPTH + 1);

   cmd_type        slot_ff [Q_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CW'(Q_DEPTH));
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `AKR_NEVER(a_q_overflow, clock, reset, push && full, "queue push while full")
   `AKR_NEVER(a_q_underflow, clock, reset, pop && !not_empty, "queue pop while empty")

endmodule

### sv/akr_back.sv
// Back end: key status/stamp tables, press/release/clear updates, scan walk.
// Depends on akr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module akr_back
   import akr_pkg::*;
#(
   parameter int NUM_KEYS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  cfg_type cfg,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int AW = (NUM_KEYS > 2) ? $clog2(NUM_KEYS) : 1;
   localparam logic [AW-1:0] FIRST_KEY = AW'(1);
   localparam logic [AW-1:0] LAST_KEY  = AW'(NUM_KEYS - 1);

   back_state_type state_ff, state_in;

   // tables: status has per-entry valid bits, stamp is only read after a press
   status_type     stat_mem [NUM_KEYS];
   logic [31:0]    stamp_mem [NUM_KEYS];
   logic [NUM_KEYS-1:0] stat_vld_ff, stat_vld_in;
   status_type     stat_rd_ff;
   logic [31:0]    stamp_rd_ff;
   logic           rd_vld_ff;

   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   status_type     wr_stat;
   logic           wr_stamp_en;
   logic           clear_all;

   logic [AW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  key_ff, key_in;
   logic [31:0]    now_ff, now_in;
   logic           ex_vld_ff, ex_vld_in;
   logic [AW-1:0]  ex_key_ff, ex_key_in;
   logic           pend_ff, pend_in;
   logic           act_ff, act_in;
   logic           hold_vld_ff, hold_vld_in;
   logic [1:0]     hold_kind_ff, hold_kind_in;
   logic [AW-1:0]  hold_key_ff, hold_key_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   rsp_type        rsp_item_ff, rsp_item_in;

   status_type     cur_stat;
   logic [31:0]    dt;
   logic           gt_delay, gt_period, over_limit;
   logic           new_ev;
   logic [1:0]     new_kind;

   assign cur_stat   = rd_vld_ff ? stat_rd_ff : ST_IDLE;
   assign dt         = now_ff - stamp_rd_ff;
   assign gt_delay   = dt > {16'd0, cfg.first_delay};
   assign gt_period  = dt > {16'd0, cfg.period};
   assign over_limit = (cfg.max_repeats != NO_LIMIT) && ({16'd0, dt} > cfg.limit);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == OP_PRESS) begin
                  state_in = B_PRESS;
               end else if (cmd.op == OP_SCAN && pend_ff) begin
                  state_in = B_SCAN;
               end
            end
         end
         B_PRESS:    state_in = B_IDLE;
         B_SCAN: begin
            if (idx_ff == LAST_KEY) begin
               state_in = B_SCAN_END;
            end
         end
         B_SCAN_END: state_in = B_FLUSH;
         B_FLUSH:    state_in = B_IDLE;
         default:    state_in = B_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cmd_pop       = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = ex_key_ff;
      wr_stat       = ST_IDLE;
      wr_stamp_en   = 1'b0;
      clear_all     = 1'b0;
      idx_in        = idx_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      ex_vld_in     = 1'b0;
      ex_key_in     = idx_ff;
      pend_in       = pend_ff;
      act_in        = act_ff;
      hold_vld_in   = hold_vld_ff;
      hold_kind_in  = hold_kind_ff;
      hold_key_in   = hold_key_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in.event_kind = hold_kind_ff;
      rsp_item_in.event_key  = 6'(hold_key_ff);
      rsp_item_in.last       = 1'b0;
      new_ev        = 1'b0;
      new_kind      = EV_PRESSED;

      case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  OP_PRESS: begin
                     rd_addr = cmd.key[AW-1:0];
                     key_in  = cmd.key[AW-1:0];
                     now_in  = cmd.now_ms;
                  end
                  OP_RELEASE: begin
                     wr_en   = 1'b1;
                     wr_addr = cmd.key[AW-1:0];
                     wr_stat = ST_RELEASED;
                     pend_in = 1'b1;
                  end
                  OP_SCAN: begin
                     idx_in = FIRST_KEY;
                     now_in = cmd.now_ms;
                     act_in = 1'b0;
                  end
                  default: begin
                     clear_all = 1'b1;
                     pend_in   = 1'b0;
                  end
               endcase
            end
         end
         B_PRESS: begin
            pend_in = 1'b1;
            wr_addr = key_ff;
            if (cur_stat != ST_FIRST && cur_stat != ST_REPEAT) begin
               wr_en       = 1'b1;
               wr_stat     = ST_PRESSED;
               wr_stamp_en = 1'b1;
            end
         end
         B_SCAN: begin
            rd_addr   = idx_ff;
            ex_vld_in = 1'b1;
            ex_key_in = idx_ff;
            idx_in    = idx_ff + 1'b1;
         end
         B_FLUSH: begin
            pend_in = act_ff;
            if (hold_vld_ff) begin
               rsp_strobe_in    = 1'b1;
               rsp_item_in.last = 1'b1;
               hold_vld_in      = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // scan execute stage: one key per cycle, read data already registered
      if (ex_vld_ff) begin
         wr_addr = ex_key_ff;
         case (cur_stat)
            ST_PRESSED: begin
               new_ev   = 1'b1;
               new_kind = EV_PRESSED;
               wr_en    = 1'b1;
               wr_stat  = ST_FIRST;
               act_in   = 1'b1;
            end
            ST_FIRST: begin
               act_in = 1'b1;
               if (gt_delay) begin
                  new_ev      = 1'b1;
                  new_kind    = EV_REPEATED;
                  wr_en       = 1'b1;
                  wr_stat     = ST_REPEAT;
                  wr_stamp_en = 1'b1;
               end
            end
            ST_REPEAT: begin
               act_in = 1'b1;
               if (gt_period) begin
                  new_ev      = 1'b1;
                  wr_stamp_en = 1'b1;
                  if (over_limit) begin
                     new_kind = EV_RELEASED;
                     wr_en    = 1'b1;
                     wr_stat  = ST_REL_IDLE;
                  end else begin
                     new_kind = EV_REPEATED;
                  end
               end
            end
            ST_RELEASED: begin
               new_ev   = 1'b1;
               new_kind = EV_RELEASED;
               wr_en    = 1'b1;
               wr_stat  = ST_REL_IDLE;
               act_in   = 1'b1;
            end
            ST_REL_IDLE: begin
               wr_en   = 1'b1;
               wr_stat = ST_IDLE;
            end
            default: begin
            end
         endcase
      end

      // one-event hold so the final event of a scan can carry last
      if (new_ev) begin
         if (hold_vld_ff) begin
            rsp_strobe_in = 1'b1;
         end
         hold_vld_in  = 1'b1;
         hold_kind_in = new_kind;
         hold_key_in  = ex_key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         ex_vld_ff     <= 1'b0;
         pend_ff       <= 1'b0;
         hold_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         stat_vld_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         ex_vld_ff     <= ex_vld_in;
         pend_ff       <= pend_in;
         hold_vld_ff   <= hold_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         stat_vld_ff   <= stat_vld_in;
      end
   end

   always_comb begin
      stat_vld_in = stat_vld_ff;
      if (clear_all) begin
         stat_vld_in = '0;
      end else if (wr_en) begin
         stat_vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      key_ff       <= key_in;
      now_ff       <= now_in;
      ex_key_ff    <= ex_key_in;
      act_ff       <= act_in;
      hold_kind_ff <= hold_kind_in;
      hold_key_ff  <= hold_key_in;
      rsp_item_ff  <= rsp_item_in;
   end

   // table memories: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stat_mem[wr_addr] <= wr_stat;
      end
      if (wr_stamp_en) begin
         stamp_mem[wr_addr] <= now_ff;
      end
      stat_rd_ff  <= stat_mem[rd_addr];
      stamp_rd_ff <= stamp_mem[rd_addr];
      rd_vld_ff   <= stat_vld_ff[rd_addr];
   end

   `AKR_ASSERT(a_flush_no_ex, clock, reset, (state_ff == B_FLUSH) |-> !ex_vld_ff, "key in flight at flush")
   `AKR_ASSERT(a_idle_no_hold, clock, reset, (state_ff == B_IDLE) |-> !hold_vld_ff, "event held while idle")
   `AKR_ASSERT(a_last_gap, clock, reset, (rsp_strobe_ff && rsp_item_ff.last) |=> !rsp_strobe_ff, "event right after last")

endmodule

### sv/key_autorepeat_controller.sv
// Top level of the key auto-repeat (typematic) controller.
// Depends on akr_pkg, akr_front, akr_queue and akr_back.
//
// Requests enter on start/busy and land in a two-entry queue; a back end
// drains it one request at a time. A press is taken in B_IDLE and written
// in B_PRESS; release and clear are done as B_IDLE takes them. A scan with
// work pending is taken in B_IDLE, walks one key entry per cycle for keys 1
// to NUM_KEYS-1 in B_SCAN through the status/stamp memory read port, then
// finishes the last key in B_SCAN_END and emits the final event in B_FLUSH;
// a scan with nothing pending is only taken in B_IDLE. Events leave on
// rsp_strobe/rsp_item, at most one per cycle, one held event behind the walk
// so that the last event of a scan can carry the last flag. The receiver
// cannot stall, so every strobe is a delivered event. busy is high only
// while the queue is full. Configuration writes are registered, and the
// repeat limit product (period times max repeats) is registered from them.
module key_autorepeat_controller
   import akr_pkg::*;
#(
   parameter int NUM_KEYS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   // event channel
   output logic        rsp_strobe,
   output rsp_type     rsp_item,
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic        q_full;
   logic        q_push;
   cmd_type     q_cmd;
   cmd_type     q_head;
   logic        q_not_empty;
   logic        q_pop;

   logic [15:0] first_delay_ff;
   logic [15:0] period_ff;
   logic [31:0] max_repeats_ff;
   logic [47:0] limit_ff, limit_in;
   cfg_type     cfg;

   // configuration registers; an index past the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff <= FIRST_DELAY_RESET;
         period_ff      <= PERIOD_RESET;
         max_repeats_ff <= NO_LIMIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_DELAY: first_delay_ff <= csr_wdata[15:0];
            CSR_PERIOD:      period_ff      <= csr_wdata[15:0];
            CSR_MAX_REPEATS: max_repeats_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // forced-release threshold, 16x32 product, registered
   assign limit_in = {32'd0, period_ff} * {16'd0, max_repeats_ff};

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
   end

   assign cfg.first_delay = first_delay_ff;
   assign cfg.period      = period_ff;
   assign cfg.max_repeats = max_repeats_ff;
   assign cfg.limit       = limit_ff;

   // front: accept and classify requests
   akr_front #(
      .NUM_KEYS (NUM_KEYS)
   ) u_front (
      .start    (start),
      .req_item (req_item),
      .q_full   (q_full),
      .busy     (busy),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   // queue decouples acceptance from table work
   akr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_cmd),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // back: key tables and scan walk
   akr_back #(
      .NUM_KEYS (NUM_KEYS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_not_empty),
      .cmd        (q_head),
      .cmd_pop    (q_pop),
      .cfg        (cfg),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

### tb/tb_key_autorepeat_controller.sv
// Self-checking testbench for key_autorepeat_controller: press, release, scan and clear
// requests against a cycle-free typematic predictor kept in a small scoreboard class.
// Depends on akr_pkg and the key_autorepeat_controller RTL only.
module tb_key_autorepeat_controller;
   import akr_pkg::*;

   localparam int NUM_KEYS = 64;
   // A scan with work pending walks every key entry, and up to two more requests
   // can sit in the queue behind it. Let that much time pass before reconfiguring.
   localparam int SETTLE_CYCLES = 4 * (NUM_KEYS + 2);
   // Bound on waiting for due events before calling them lost.
   localparam int DRAIN_GUARD = 5000;
   localparam int PHASE_ITEMS = 26;
   // Index past the register list; writes to it are dropped.
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // ------------------------------------------------------------------
   // Typematic predictor plus the queue of events still due from the DUT
   // ------------------------------------------------------------------
   class typematic_model;
      status_type  status [NUM_KEYS];
      logic [31:0] stamp  [NUM_KEYS];
      bit          scan_pending;
      logic [15:0] first_delay;
      logic [15:0] period;
      logic [31:0] max_repeats;
      rsp_type     due_events[$];
      int          mismatches;

      function new();
         first_delay = FIRST_DELAY_RESET;
         period      = PERIOD_RESET;
         max_repeats = NO_LIMIT;
         mismatches  = 0;
         wipe_table();
      endfunction

      task flag(string msg);
         mismatches++;
         if (mismatches <= 200)
            $display("MISMATCH @%0t: %s", $realtime, msg);
      endtask

      function void wipe_table();
         foreach (status[i]) begin
            status[i] = ST_IDLE;
            stamp[i]  = '0;
         end
         scan_pending = 1'b0;
      endfunction

      // Registers only narrower than the data bus keep their low bits.
      function void set_register(logic [1:0] idx, logic [31:0] data);
         case (idx)
            CSR_FIRST_DELAY: first_delay = data[15:0];
            CSR_PERIOD:      period      = data[15:0];
            CSR_MAX_REPEATS: max_repeats = data;
            default: ;
         endcase
      endfunction

      function void run_scan(logic [31:0] now);
         rsp_type     ev;
         rsp_type     batch[$];
         logic [31:0] dt;
         logic [47:0] limit;
         bit          active;
         if (!scan_pending)
            return;
         active = 1'b0;
         limit  = 48'(period) * 48'(max_repeats);
         for (int k = 1; k < NUM_KEYS; k++) begin
            dt = now - stamp[k];
            ev.event_key = 6'(k);
            ev.last      = 1'b0;
            case (status[k])
               ST_PRESSED: begin
                  ev.event_kind = EV_PRESSED;
                  batch = {batch, ev};
                  status[k] = ST_FIRST;
                  active = 1'b1;
               end
               ST_FIRST: begin
                  if (dt > 32'(first_delay)) begin
                     ev.event_kind = EV_REPEATED;
                     batch = {batch, ev};
                     status[k] = ST_REPEAT;
                     stamp[k]  = now;
                  end
                  active = 1'b1;
               end
               ST_REPEAT: begin
                  if (dt > 32'(period)) begin
                     if (max_repeats != NO_LIMIT && 48'(dt) > limit) begin
                        ev.event_kind = EV_RELEASED;
                        status[k] = ST_REL_IDLE;
                     end else begin
                        ev.event_kind = EV_REPEATED;
                     end
                     batch = {batch, ev};
                     stamp[k] = now;
                  end
                  active = 1'b1;
               end
               ST_RELEASED: begin
                  ev.event_kind = EV_RELEASED;
                  batch = {batch, ev};
                  status[k] = ST_REL_IDLE;
                  active = 1'b1;
               end
               ST_REL_IDLE: status[k] = ST_IDLE;
               default: ;
            endcase
         end
         scan_pending = active;
         if (batch.size() != 0)
            batch[batch.size() - 1].last = 1'b1;
         due_events = {due_events, batch};
      endfunction

      // Called once per accepted request, in acceptance order.
      function void note_request(req_type r);
         case (r.func)
            FUNC_PRESS: begin
               if (r.key != 0) begin
                  scan_pending = 1'b1;
                  if (status[r.key] != ST_FIRST && status[r.key] != ST_REPEAT) begin
                     stamp[r.key]  = r.now_ms;
                     status[r.key] = ST_PRESSED;
                  end
               end
            end
            FUNC_RELEASE: begin
               if (r.key != 0) begin
                  scan_pending = 1'b1;
                  status[r.key] = ST_RELEASED;
               end
            end
            FUNC_SCAN: run_scan(r.now_ms);
            default:   wipe_table();
         endcase
      endfunction

      task check_event(rsp_type got);
         rsp_type want;
         if (due_events.size() == 0) begin
            flag($sformatf("unexpected event kind=%0d key=%0d last=%0b",
                           got.event_kind, got.event_key, got.last));
            return;
         end
         want = due_events.pop_front();
         if (got.event_kind !== want.event_kind)
            flag($sformatf("event_kind %0d, want %0d (key %0d)",
                           got.event_kind, want.event_kind, want.event_key));
         if (got.event_key !== want.event_key)
            flag($sformatf("event_key %0d, want %0d", got.event_key, want.event_key));
         if (got.last !== want.last)
            flag($sformatf("last %0b, want %0b (key %0d)", got.last, want.last,
                           want.event_key));
      endtask
   endclass

   // ------------------------------------------------------------------
   // DUT and its signals; every input starts at a known value
   // ------------------------------------------------------------------
   logic        clock;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic        busy;
   req_type     req_item  = '0;
   logic        rsp_strobe;
   rsp_type     rsp_item;
   logic        csr_we    = 1'b0;
   logic [1:0]  csr_index = CSR_FIRST_DELAY;
   logic [31:0] csr_wdata = '0;

   typematic_model book = new();

   // Running millisecond clock handed to press and scan requests.
   logic [31:0] t_ms;
   bit          gaps_on;

   key_autorepeat_controller #(
      .NUM_KEYS(NUM_KEYS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the DUT hangs or loses events.
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // The receiver cannot stall, so every strobe seen at an edge is one event.
   // Sampling at the edge sees the values that a register would capture there.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         book.check_event(rsp_item);
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   function automatic req_type make_req(logic [1:0] f, logic [5:0] k, logic [31:0] now);
      req_type r;
      r.func   = f;
      r.key    = k;
      r.now_ms = now;
      return r;
   endfunction

   // Present one request and hold it until an edge with busy low takes it.
   // start stays high on return so back-to-back requests need no dip.
   task automatic send(req_type r);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      book.note_request(r);
   endtask

   task automatic pause(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Random idle burst on the request side, when gaps are enabled.
   task automatic maybe_idle();
      if (gaps_on && $urandom_range(0, 3) == 0)
         pause($urandom_range(1, 10));
   endtask

   // Stop sending, wait for every due event, then let the back end finish any
   // scan that emits nothing. Always advances at least one edge.
   task automatic drain(int extra);
      int waited;
      start  <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (book.due_events.size() != 0 && waited < DRAIN_GUARD);
      if (book.due_events.size() != 0) begin
         book.flag($sformatf("%0d events never arrived", book.due_events.size()));
         book.due_events.delete();
      end
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      book.set_register(idx, data);
   endtask

   // Full register set; upper bits of the 16-bit registers carry junk that must
   // be dropped. The wait at the end covers the registered repeat-limit product.
   task automatic configure(logic [15:0] delay, logic [15:0] per, logic [31:0] maxr);
      write_register(CSR_FIRST_DELAY, {16'($urandom), delay});
      write_register(CSR_PERIOD, {16'($urandom), per});
      write_register(CSR_MAX_REPEATS, maxr);
      csr_we <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // Mostly a handful of low keys so each goes through its whole life cycle.
   function automatic logic [5:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7)
         return 6'($urandom_range(1, 4));
      if (r == 7)
         return 6'd63;
      return 6'($urandom_range(0, 63));
   endfunction

   // Advance the millisecond clock on a scale set by the current timing.
   function automatic void advance_time();
      int unsigned span;
      int          r;
      span = (book.first_delay > book.period) ? book.first_delay : book.period;
      r    = $urandom_range(0, 39);
      if (r == 0)
         t_ms = t_ms + $urandom;
      else if (r < 4)
         t_ms = t_ms + $urandom_range(0, 3 * span + 3);
      else
         t_ms = t_ms + $urandom_range(0, span / 2 + 1);
   endfunction

   // Well-formed traffic (press, scans over time, release) with a little noise.
   task automatic random_phase(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         advance_time();
         pick = $urandom_range(0, 99);
         if (pick < 30)
            send(make_req(FUNC_PRESS, pick_key(), t_ms));
         else if (pick < 46)
            send(make_req(FUNC_RELEASE, pick_key(), t_ms));
         else if (pick < 94)
            send(make_req(FUNC_SCAN, pick_key(), t_ms));
         else if (pick < 97)
            send(make_req(FUNC_CLEAR, 6'($urandom), $urandom));
         else
            send(make_req(2'($urandom), 6'($urandom), $urandom));
         // Sender holds off once per phase until every event has come back.
         if (i == count / 2)
            drain(0);
         else
            maybe_idle();
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      logic [31:0] t0;
      t0      = 32'hFFFF_FF00;   // near the wrap so repeat timing crosses zero
      gaps_on = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset timing (600 ms delay, 150 ms period, no limit).
      send(make_req(FUNC_SCAN, 6'd0, t0));          // nothing pending: no events
      send(make_req(FUNC_PRESS, 6'd0, t0));         // key zero is ignored
      send(make_req(FUNC_RELEASE, 6'd0, t0));
      send(make_req(FUNC_SCAN, 6'd5, t0));          // still nothing pending
      send(make_req(FUNC_PRESS, 6'd1, t0));
      send(make_req(FUNC_PRESS, 6'd63, t0));
      send(make_req(FUNC_SCAN, 6'd0, t0 + 1));      // pressed 1, pressed 63
      send(make_req(FUNC_SCAN, 6'd0, t0 + 600));    // exactly the delay: no repeat
      send(make_req(FUNC_SCAN, 6'd0, t0 + 601));    // first repeat, across the wrap
      send(make_req(FUNC_PRESS, 6'd1, t0 + 650));   // held while repeating: stamp kept
      send(make_req(FUNC_SCAN, 6'd0, t0 + 751));    // exactly the period: nothing
      send(make_req(FUNC_SCAN, 6'd0, t0 + 752));    // repeat on both keys
      send(make_req(FUNC_RELEASE, 6'd63, t0 + 755));
      send(make_req(FUNC_SCAN, 6'd0, t0 + 760));    // released 63
      send(make_req(FUNC_SCAN, 6'd0, t0 + 761));    // 63 back to idle, 1 still active
      send(make_req(FUNC_CLEAR, 6'd63, 32'hFFFF_FFFF));
      send(make_req(FUNC_SCAN, 6'd0, 32'd0));       // table empty: no events
      send(make_req(FUNC_PRESS, 6'd2, 32'd5));
      send(make_req(FUNC_RELEASE, 6'd2, 32'd6));    // release before pressed is seen
      send(make_req(FUNC_SCAN, 6'd0, 32'd7));       // released 2 only
      send(make_req(FUNC_SCAN, 6'd0, 32'd8));
      send(make_req(FUNC_SCAN, 6'd0, 32'd9));       // no longer pending
      drain(SETTLE_CYCLES);

      // Short timing with a small repeat limit: forced releases are common.
      gaps_on = 1'b1;
      configure(16'd10, 16'd4, 32'd3);
      t_ms = $urandom;
      random_phase(PHASE_ITEMS);
      drain(SETTLE_CYCLES);

      // All zero: any elapsed time repeats a key and the next expiry releases it.
      configure(16'd0, 16'd0, 32'd0);
      t_ms = $urandom;
      random_phase(PHASE_ITEMS);
      drain(SETTLE_CYCLES);

      // Longest timing; the limit product no longer fits in 32 bits.
      configure(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFE);
      t_ms = $urandom;
      random_phase(PHASE_ITEMS);
      drain(SETTLE_CYCLES);

      // Tiny timing, unlimited repeats; a write to the spare index must do nothing.
      configure(16'd1, 16'd2, NO_LIMIT);
      write_register(CSR_SPARE, $urandom);
      csr_we <= 1'b0;
      repeat (2) @(posedge clock);
      t_ms = $urandom;
      random_phase(PHASE_ITEMS);
      drain(SETTLE_CYCLES);

      // Final stretch: random small timing, requests back to back.
      gaps_on = 1'b0;
      configure(16'($urandom_range(0, 30)), 16'($urandom_range(0, 15)),
                32'($urandom_range(0, 6)));
      t_ms = $urandom;
      random_phase(PHASE_ITEMS);
      drain(SETTLE_CYCLES);

      if (book.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### key_autorepeat_controller.f
+incdir+sv
sv/akr_pkg.sv
sv/akr_front.sv
sv/akr_queue.sv
sv/akr_back.sv
sv/key_autorepeat_controller.sv
tb/tb_key_autorepeat_controller.sv
